// ----- hdl/cfct_pkg.sv -----
// ----------------------------------------------------------------------------
// cfct_pkg
// Shared types and constants for the client flow counter table.
// ----------------------------------------------------------------------------
package cfct_pkg;

    localparam int unsigned BUCKETS_DEF = 1024;
    localparam int unsigned WAYS_DEF    = 4;

    localparam int unsigned IP_W   = 32;
    localparam int unsigned PORT_W = 16;
    localparam int unsigned KEY_W  = IP_W + PORT_W;
    localparam int unsigned CNT_W  = 32;
    localparam int unsigned HASH_W = 32;

    localparam logic [HASH_W-1:0] MIX_C1 = 32'd2654435761;
    localparam logic [HASH_W-1:0] MIX_C2 = 32'd2246822519;
    localparam logic [HASH_W-1:0] MIX_C3 = 32'd3266489917;

    localparam logic CMD_COUNT  = 1'b0;
    localparam logic CMD_FORGET = 1'b1;

    typedef enum logic [1:0] {
        TS_CLEAR,
        TS_IDLE,
        TS_EVAL
    } t_tbl_state;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             present;
        logic             full;
    } t_result;

endpackage

// ----- hdl/cfct_hash.sv -----
// ----------------------------------------------------------------------------
// cfct_hash
// Pipelined multiply-xorshift mix of the client key, reduced to a bucket.
// ----------------------------------------------------------------------------
module cfct_hash #(
    parameter int unsigned BUCKETS = cfct_pkg::BUCKETS_DEF,
    parameter int unsigned BW      = $clog2(BUCKETS)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [cfct_pkg::IP_W-1:0]   i_ip,
    input  logic [cfct_pkg::PORT_W-1:0] i_port,
    output logic                        o_done,
    output logic [BW-1:0]               o_bucket
);

    localparam bit IS_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

    logic [cfct_pkg::HASH_W-1:0] r_x1;
    logic [cfct_pkg::HASH_W-1:0] r_x2;
    logic [cfct_pkg::HASH_W-1:0] r_x3;
    logic                        r_v1;
    logic                        r_v2;
    logic                        r_v3;
    logic [cfct_pkg::HASH_W-1:0] port_mul;
    logic [cfct_pkg::HASH_W-1:0] s1;
    logic [cfct_pkg::HASH_W-1:0] s2;
    logic [cfct_pkg::HASH_W-1:0] h;
    logic [BW-1:0]               r_rem;
    logic                        r_done;

    assign port_mul = cfct_pkg::HASH_W'(i_port) * cfct_pkg::MIX_C1;
    assign s1       = r_x1 ^ (r_x1 >> 16);
    assign s2       = r_x2 ^ (r_x2 >> 13);
    assign h        = r_x3 ^ (r_x3 >> 16);

    // one multiply per stage
    always_ff @(posedge i_clk) begin
        r_x1 <= i_ip ^ port_mul;
        r_x2 <= s1 * cfct_pkg::MIX_C2;
        r_x3 <= s2 * cfct_pkg::MIX_C3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    generate
        if (IS_POW2) begin : g_mask
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                end else begin
                    r_done <= r_v3;
                end
            end

            always_ff @(posedge i_clk) begin
                if (r_v3) begin
                    r_rem <= h[BW-1:0];
                end
            end
        end else begin : g_recip
            // q = (h * M) >> (32 + BW) with M = ceil(2^(32+BW) / BUCKETS) is exact
            // for every 32-bit h; the remainder is h - q * BUCKETS
            localparam int unsigned PW = 2 * cfct_pkg::HASH_W + 1;
            localparam logic [63:0] MAGIC =
                ((64'd1 << (cfct_pkg::HASH_W + BW)) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
            localparam logic [cfct_pkg::HASH_W-1:0] M_LO = MAGIC[cfct_pkg::HASH_W-1:0];
            localparam logic                        M_HI = MAGIC[cfct_pkg::HASH_W];

            logic [PW-1:0]               prod;
            logic [PW-1:0]               r_prod;
            logic [cfct_pkg::HASH_W-1:0] r_q;
            logic [cfct_pkg::HASH_W-1:0] r_h4;
            logic [cfct_pkg::HASH_W-1:0] r_h5;
            logic [cfct_pkg::HASH_W-1:0] qb;
            logic [cfct_pkg::HASH_W-1:0] diff;
            logic                        r_v4;
            logic                        r_v5;

            assign prod = {1'b0, 64'(h) * 64'(M_LO)}
                        + (M_HI ? {1'b0, h, cfct_pkg::HASH_W'(0)} : PW'(0));
            assign qb   = r_q * cfct_pkg::HASH_W'(BUCKETS);
            assign diff = r_h5 - qb;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v4   <= 1'b0;
                    r_v5   <= 1'b0;
                    r_done <= 1'b0;
                end else begin
                    r_v4   <= r_v3;
                    r_v5   <= r_v4;
                    r_done <= r_v5;
                end
            end

            always_ff @(posedge i_clk) begin
                if (r_v3) begin
                    r_prod <= prod;
                    r_h4   <= h;
                end
                if (r_v4) begin
                    r_q  <= cfct_pkg::HASH_W'(r_prod >> (cfct_pkg::HASH_W + BW));
                    r_h5 <= r_h4;
                end
                if (r_v5) begin
                    r_rem <= diff[BW-1:0];
                end
            end
        end
    endgenerate

    assign o_done   = r_done;
    assign o_bucket = r_rem;

endmodule

// ----- hdl/cfct_table.sv -----
// ----------------------------------------------------------------------------
// cfct_table
// Bucket memories and the read-modify-write of one bucket per command.
// ----------------------------------------------------------------------------
module cfct_table #(
    parameter int unsigned BUCKETS = cfct_pkg::BUCKETS_DEF,
    parameter int unsigned WAYS    = cfct_pkg::WAYS_DEF,
    parameter int unsigned BW      = $clog2(BUCKETS)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_lookup,
    input  logic [BW-1:0]              i_bucket,
    input  logic                       i_cmd,
    input  logic [cfct_pkg::KEY_W-1:0] i_key,
    output logic                       o_ready,
    output logic                       o_res_valid,
    output cfct_pkg::t_result          o_res
);

    localparam int unsigned ENT_W = cfct_pkg::KEY_W + cfct_pkg::CNT_W;
    localparam int unsigned ROW_W = WAYS * ENT_W;
    localparam int unsigned WW    = (WAYS > 1) ? $clog2(WAYS) : 1;

    logic [WAYS-1:0]  vmem [BUCKETS];
    logic [ROW_W-1:0] dmem [BUCKETS];

    cfct_pkg::t_tbl_state r_state;
    cfct_pkg::t_tbl_state n_state;

    logic [BW-1:0]             r_clr_idx;
    logic [BW-1:0]             r_bucket;
    logic [WAYS-1:0]           r_vrd;
    logic [ROW_W-1:0]          r_drd;
    logic                      r_res_valid;
    cfct_pkg::t_result         r_res;
    logic                      n_res_valid;
    cfct_pkg::t_result         n_res;

    logic                      rd_en;
    logic                      vm_we;
    logic [BW-1:0]             vm_addr;
    logic [WAYS-1:0]           vm_wdata;
    logic                      dm_we;
    logic [ROW_W-1:0]          dm_wdata;
    logic                      hit;
    logic [WW-1:0]             hit_way;
    logic                      free;
    logic [WW-1:0]             free_way;
    logic [cfct_pkg::CNT_W-1:0] hit_cnt;
    logic [cfct_pkg::CNT_W-1:0] inc_cnt;

    // way search over the registered bucket row, lowest way wins
    always_comb begin
        hit      = 1'b0;
        hit_way  = '0;
        free     = 1'b0;
        free_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (r_vrd[w]) begin
                if (r_drd[w*ENT_W + cfct_pkg::CNT_W +: cfct_pkg::KEY_W] == i_key) begin
                    hit     = 1'b1;
                    hit_way = WW'(w);
                end
            end else begin
                free     = 1'b1;
                free_way = WW'(w);
            end
        end
    end

    assign hit_cnt = r_drd[hit_way*ENT_W +: cfct_pkg::CNT_W];
    assign inc_cnt = hit_cnt + 1'b1;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            cfct_pkg::TS_CLEAR: begin
                if (r_clr_idx == BW'(BUCKETS - 1)) begin
                    n_state = cfct_pkg::TS_IDLE;
                end
            end
            cfct_pkg::TS_IDLE: begin
                if (i_lookup) begin
                    n_state = cfct_pkg::TS_EVAL;
                end
            end
            cfct_pkg::TS_EVAL: begin
                n_state = cfct_pkg::TS_IDLE;
            end
            default: begin
                n_state = cfct_pkg::TS_CLEAR;
            end
        endcase
    end

    // outputs and memory writes
    always_comb begin
        rd_en       = 1'b0;
        vm_we       = 1'b0;
        vm_addr     = r_bucket;
        vm_wdata    = r_vrd;
        dm_we       = 1'b0;
        dm_wdata    = r_drd;
        n_res_valid = 1'b0;
        n_res       = '0;
        case (r_state)
            cfct_pkg::TS_CLEAR: begin
                vm_we    = 1'b1;
                vm_addr  = r_clr_idx;
                vm_wdata = '0;
            end
            cfct_pkg::TS_IDLE: begin
                rd_en = i_lookup;
            end
            cfct_pkg::TS_EVAL: begin
                n_res_valid = 1'b1;
                if (i_cmd == cfct_pkg::CMD_COUNT) begin
                    if (hit) begin
                        dm_we = 1'b1;
                        dm_wdata[hit_way*ENT_W +: cfct_pkg::CNT_W] = inc_cnt;
                        n_res.count   = inc_cnt;
                        n_res.present = 1'b1;
                    end else if (free) begin
                        dm_we = 1'b1;
                        vm_we = 1'b1;
                        dm_wdata[free_way*ENT_W +: ENT_W] = {i_key, cfct_pkg::CNT_W'(1)};
                        vm_wdata[free_way] = 1'b1;
                        n_res.count = cfct_pkg::CNT_W'(1);
                    end else begin
                        n_res.full = 1'b1;
                    end
                end else if (hit) begin
                    vm_we = 1'b1;
                    vm_wdata[hit_way] = 1'b0;
                    n_res.present = 1'b1;
                end
            end
            default: begin
                vm_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cfct_pkg::TS_CLEAR;
            r_clr_idx   <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
            if (r_state == cfct_pkg::TS_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (rd_en) begin
            r_bucket <= i_bucket;
        end
    end

    // bucket memories, registered read
    always_ff @(posedge i_clk) begin
        if (vm_we) begin
            vmem[vm_addr] <= vm_wdata;
        end
        if (rd_en) begin
            r_vrd <= vmem[i_bucket];
        end
    end

    always_ff @(posedge i_clk) begin
        if (dm_we) begin
            dmem[r_bucket] <= dm_wdata;
        end
        if (rd_en) begin
            r_drd <= dmem[i_bucket];
        end
    end

    assign o_ready     = (r_state != cfct_pkg::TS_CLEAR);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

// ----- hdl/client_flow_counter_table_unit.sv -----
// Pipeline: for non-power-of-two BUCKETS two extra stages take the remainder
//   by reciprocal multiply.
// Throughput: one command at a time; busy covers it.
// Reset: synchronous; afterwards a pass clears the valid memory one bucket per cycle,
//   with busy high. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
// client_flow_counter_table_unit
// Hashed per-client packet counter table with WAYS entries per bucket.
// ----------------------------------------------------------------------------
module client_flow_counter_table_unit #(
    parameter int unsigned BUCKETS = cfct_pkg::BUCKETS_DEF,
    parameter int unsigned WAYS    = cfct_pkg::WAYS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_command,
    input  logic [cfct_pkg::IP_W-1:0]   i_client_ip,
    input  logic [cfct_pkg::PORT_W-1:0] i_client_port,
    output logic                        o_valid,
    output logic [cfct_pkg::CNT_W-1:0]  o_count_value,
    output logic                        o_was_present,
    output logic                        o_status
);

    localparam int unsigned BW = $clog2(BUCKETS);

    logic                          accept;
    logic                          r_busy;
    logic                          r_cmd;
    logic [cfct_pkg::KEY_W-1:0]    r_key;
    logic                          hash_done;
    logic [BW-1:0]                 hash_bucket;
    logic                          tbl_ready;
    logic                          res_valid;
    cfct_pkg::t_result             res;

    assign accept = start && !busy;
    assign busy   = r_busy || !tbl_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (accept) begin
            r_busy <= 1'b1;
        end else if (res_valid) begin
            r_busy <= 1'b0;
        end
    end

    // hold the command beat while it is in flight
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_command;
            r_key <= {i_client_ip, i_client_port};
        end
    end

    cfct_hash #(
        .BUCKETS (BUCKETS),
        .BW      (BW)
    ) u_hash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (accept),
        .i_ip     (i_client_ip),
        .i_port   (i_client_port),
        .o_done   (hash_done),
        .o_bucket (hash_bucket)
    );

    cfct_table #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS),
        .BW      (BW)
    ) u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_lookup    (hash_done),
        .i_bucket    (hash_bucket),
        .i_cmd       (r_cmd),
        .i_key       (r_key),
        .o_ready     (tbl_ready),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    assign o_valid       = res_valid;
    assign o_count_value = res.count;
    assign o_was_present = res.present;
    assign o_status      = res.full;

endmodule

// ----- dv/tb_client_flow_counter_table_unit.sv -----
// ----------------------------------------------------------------------------
// tb_client_flow_counter_table_unit
// Self-checking bench for the hashed per-client counter table. Commands are
// driven through the start/busy handshake with random idle gaps. Each
// accepted beat is run through a behavioral copy of the table, and the
// result it predicts is queued. Every strobed result is compared with the
// oldest prediction.
// ----------------------------------------------------------------------------
module tb_client_flow_counter_table_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned NUM_BUCKETS = cfct_pkg::BUCKETS_DEF;
    localparam int unsigned NUM_WAYS    = cfct_pkg::WAYS_DEF;
    // covers the clearing pass, the longest sender gap and the slowest lookup
    localparam int unsigned STALL_LIMIT = 4 * NUM_BUCKETS + 1000;
    localparam int unsigned RANDOM_BEATS = 1830;

    // Behavioral copy of the table plus the queue of predicted results.
    class flow_count_tracker;
        bit                          slot_used  [NUM_BUCKETS*NUM_WAYS];
        logic [cfct_pkg::KEY_W-1:0]  slot_key   [NUM_BUCKETS*NUM_WAYS];
        logic [cfct_pkg::CNT_W-1:0]  slot_count [NUM_BUCKETS*NUM_WAYS];
        cfct_pkg::t_result           expected_results[$];
        int                          failures;

        function int unsigned bucket_of(logic [cfct_pkg::IP_W-1:0] ip,
                                        logic [cfct_pkg::PORT_W-1:0] port);
            logic [cfct_pkg::HASH_W-1:0] x;
            x = ip ^ (port * cfct_pkg::MIX_C1);
            x = x ^ (x >> 16);
            x = x * cfct_pkg::MIX_C2;
            x = x ^ (x >> 13);
            x = x * cfct_pkg::MIX_C3;
            x = x ^ (x >> 16);
            return x % NUM_BUCKETS;
        endfunction

        function void flag(string msg);
            if (failures < 10) begin
                $display("%s", msg);
            end
            failures++;
        endfunction

        // Apply one accepted command to the table and queue its result.
        function void accept_item(logic cmd, logic [cfct_pkg::IP_W-1:0] ip,
                                  logic [cfct_pkg::PORT_W-1:0] port);
            logic [cfct_pkg::KEY_W-1:0] key;
            int unsigned                base;
            int                         hit;
            int                         free_way;
            cfct_pkg::t_result          res;
            key      = {ip, port};
            base     = bucket_of(ip, port) * NUM_WAYS;
            hit      = -1;
            free_way = -1;
            res      = '0;
            for (int w = 0; w < NUM_WAYS; w++) begin
                if (slot_used[base+w]) begin
                    if (hit < 0 && slot_key[base+w] == key) hit = w;
                end else if (free_way < 0) begin
                    free_way = w;
                end
            end
            if (cmd == cfct_pkg::CMD_COUNT) begin
                if (hit >= 0) begin
                    // wraps at 2^32; too many hits for this run to reach
                    slot_count[base+hit] = slot_count[base+hit] + 1'b1;
                    res.count            = slot_count[base+hit];
                    res.present          = 1'b1;
                end else if (free_way >= 0) begin
                    slot_used[base+free_way]  = 1'b1;
                    slot_key[base+free_way]   = key;
                    slot_count[base+free_way] = cfct_pkg::CNT_W'(1);
                    res.count                 = cfct_pkg::CNT_W'(1);
                end else begin
                    res.full = 1'b1;
                end
            end else if (hit >= 0) begin
                slot_used[base+hit] = 1'b0;
                res.present         = 1'b1;
            end
            expected_results.push_back(res);
        endfunction

        function void check_result(logic [cfct_pkg::CNT_W-1:0] count, logic present,
                                   logic status);
            cfct_pkg::t_result want;
            if (expected_results.size() == 0) begin
                flag($sformatf("unexpected result: count=%0h present=%b status=%b",
                               count, present, status));
                return;
            end
            want = expected_results.pop_front();
            if (count !== want.count || present !== want.present || status !== want.full) begin
                flag($sformatf({"mismatch: count exp %0h got %0h, present exp %b got %b, ",
                                "status exp %b got %b"},
                               want.count, count, want.present, present, want.full, status));
            end
        endfunction
    endclass

    logic                         i_clk         = 1'b0;
    logic                         i_rst_n       = 1'b0;
    logic                         start         = 1'b0;
    logic                         busy;
    logic                         i_command     = cfct_pkg::CMD_COUNT;
    logic [cfct_pkg::IP_W-1:0]    i_client_ip   = '0;
    logic [cfct_pkg::PORT_W-1:0]  i_client_port = '0;
    logic                         o_valid;
    logic [cfct_pkg::CNT_W-1:0]   o_count_value;
    logic                         o_was_present;
    logic                         o_status;

    flow_count_tracker  tracker = new();
    int unsigned        stall_cycles = 0;

    client_flow_counter_table_unit #(
        .BUCKETS(NUM_BUCKETS),
        .WAYS   (NUM_WAYS)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_command    (i_command),
        .i_client_ip  (i_client_ip),
        .i_client_port(i_client_port),
        .o_valid      (o_valid),
        .o_count_value(o_count_value),
        .o_was_present(o_was_present),
        .o_status     (o_status)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Check results and watch for a stuck handshake.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            tracker.check_result(o_count_value, o_was_present, o_status);
        end
        if ((start && !busy) || o_valid === 1'b1) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("** client_flow_counter_table_unit: FAILED **");
            $finish;
        end
    end

    // Hold start low for gap cycles, then present one beat until it is taken.
    task automatic send_beat(logic cmd, logic [cfct_pkg::IP_W-1:0] ip,
                             logic [cfct_pkg::PORT_W-1:0] port, int unsigned gap);
        repeat (gap) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start         <= 1'b1;
        i_command     <= cmd;
        i_client_ip   <= ip;
        i_client_port <= port;
        do @(posedge i_clk); while (busy !== 1'b0);
        tracker.accept_item(cmd, ip, port);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (tracker.expected_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [cfct_pkg::KEY_W-1:0] key_in_bucket(int unsigned b);
        logic [cfct_pkg::KEY_W-1:0] k;
        do begin
            k = {$urandom, 16'($urandom)};
        end while (tracker.bucket_of(k[cfct_pkg::KEY_W-1:cfct_pkg::PORT_W],
                                     k[cfct_pkg::PORT_W-1:0]) != b);
        return k;
    endfunction

    function automatic int unsigned idle_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    initial begin
        logic [cfct_pkg::KEY_W-1:0] crowd[5];
        logic [cfct_pkg::KEY_W-1:0] hot_keys[$];
        logic [cfct_pkg::KEY_W-1:0] warm_keys[$];
        logic [cfct_pkg::KEY_W-1:0] k;
        logic                       cmd;
        int unsigned                b;
        int unsigned                r;
        bit                         steady;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // insert, hit, extremes of the key fields
        send_beat(cfct_pkg::CMD_COUNT, '0, '0, 0);
        send_beat(cfct_pkg::CMD_COUNT, '0, '0, 0);
        send_beat(cfct_pkg::CMD_COUNT, '1, '1, 0);
        send_beat(cfct_pkg::CMD_COUNT, '1, '1, 2);
        // forget of an absent key, then of a present one, then again
        send_beat(cfct_pkg::CMD_FORGET, 32'h1234_5678, 16'h0001, 0);
        send_beat(cfct_pkg::CMD_FORGET, '0, '0, 1);
        send_beat(cfct_pkg::CMD_FORGET, '0, '0, 0);
        send_beat(cfct_pkg::CMD_COUNT, '0, '0, 0);

        // fill one bucket past its ways, punch a hole, refill it
        b = $urandom_range(0, NUM_BUCKETS - 1);
        foreach (crowd[i]) crowd[i] = key_in_bucket(b);
        foreach (crowd[i]) begin
            send_beat(cfct_pkg::CMD_COUNT, crowd[i][cfct_pkg::KEY_W-1:cfct_pkg::PORT_W],
                      crowd[i][cfct_pkg::PORT_W-1:0], 0);
        end
        send_beat(cfct_pkg::CMD_COUNT, crowd[4][cfct_pkg::KEY_W-1:cfct_pkg::PORT_W],
                  crowd[4][cfct_pkg::PORT_W-1:0], 0);
        send_beat(cfct_pkg::CMD_FORGET, crowd[1][cfct_pkg::KEY_W-1:cfct_pkg::PORT_W],
                  crowd[1][cfct_pkg::PORT_W-1:0], 0);
        send_beat(cfct_pkg::CMD_COUNT, crowd[4][cfct_pkg::KEY_W-1:cfct_pkg::PORT_W],
                  crowd[4][cfct_pkg::PORT_W-1:0], 0);
        send_beat(cfct_pkg::CMD_COUNT, crowd[2][cfct_pkg::KEY_W-1:cfct_pkg::PORT_W],
                  crowd[2][cfct_pkg::PORT_W-1:0], 3);
        send_beat(cfct_pkg::CMD_COUNT, crowd[1][cfct_pkg::KEY_W-1:cfct_pkg::PORT_W],
                  crowd[1][cfct_pkg::PORT_W-1:0], 0);
        send_beat(cfct_pkg::CMD_FORGET, crowd[0][cfct_pkg::KEY_W-1:cfct_pkg::PORT_W],
                  crowd[0][cfct_pkg::PORT_W-1:0], 0);
        send_beat(cfct_pkg::CMD_FORGET, crowd[0][cfct_pkg::KEY_W-1:cfct_pkg::PORT_W],
                  crowd[0][cfct_pkg::PORT_W-1:0], 0);

        // Hot keys crowd a few buckets so full and refill cases recur;
        // warm keys give repeated hits; the rest are fresh keys.
        repeat (4) begin
            b = $urandom_range(0, NUM_BUCKETS - 1);
            repeat (NUM_WAYS + 3) hot_keys.push_back(key_in_bucket(b));
        end
        repeat (48) warm_keys.push_back({$urandom, 16'($urandom)});

        steady = 1'b0;
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % 200 == 0) steady = ($urandom_range(0, 2) == 0);
            if (n == RANDOM_BEATS / 2) drain_results();
            r = $urandom_range(0, 99);
            if (r < 40) begin
                k = hot_keys[$urandom_range(0, hot_keys.size() - 1)];
            end else if (r < 80) begin
                k = warm_keys[$urandom_range(0, warm_keys.size() - 1)];
            end else begin
                k = {$urandom, 16'($urandom)};
            end
            cmd = ($urandom_range(0, 99) < 72) ? cfct_pkg::CMD_COUNT : cfct_pkg::CMD_FORGET;
            send_beat(cmd, k[cfct_pkg::KEY_W-1:cfct_pkg::PORT_W], k[cfct_pkg::PORT_W-1:0],
                      steady ? 0 : idle_gap());
        end

        drain_results();
        repeat (40) @(posedge i_clk);
        if (tracker.failures == 0 && tracker.expected_results.size() == 0) begin
            $display("** client_flow_counter_table_unit: PASSED **");
        end else begin
            $display("** client_flow_counter_table_unit: FAILED **");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/cfct_pkg.sv
hdl/cfct_hash.sv
hdl/cfct_table.sv
hdl/client_flow_counter_table_unit.sv
dv/tb_client_flow_counter_table_unit.sv
